@@ rtl/brw_pkg.sv @@
// ----------------------------------------------------------------------------
// Base relocation walker package
// Shared types and codes for the relocation directory walker.
// ----------------------------------------------------------------------------
package brw_pkg;

    // Result status codes.
    localparam logic [1:0] ST_WALK = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    // Patch actions.
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_ADD32 = 2'd1;
    localparam logic [1:0] ACT_ADD64 = 2'd2;

    // Relocation entry types.
    localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
    localparam logic [3:0] TYPE_DIR64   = 4'd10;

    // Block header length in bytes.
    localparam int HDR_BYTES = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIR_RVA     = 2'd0;
    localparam logic [1:0] REG_DIR_SIZE    = 2'd1;
    localparam logic [1:0] REG_BUFFER_SIZE = 2'd2;
    localparam logic [1:0] REG_DELTA       = 2'd3;

    typedef struct packed {
        logic [31:0] dir_rva;
        logic [31:0] dir_size;
        logic [31:0] buffer_size;
        logic [63:0] delta;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] patch_address;
        logic [63:0] add_value;
        logic [1:0]  status;
    } res_t;

endpackage

@@ rtl/brw_core.sv @@
// ----------------------------------------------------------------------------
// Base relocation walker core
// Holds the walk state and turns one directory byte into one result.
// ----------------------------------------------------------------------------
module brw_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_en,
    input  logic [7:0]    data_byte,
    input  logic          restart,
    input  brw_pkg::cfg_t cfg,
    output brw_pkg::res_t res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ACTIVE = 3'd1;
    localparam logic [2:0] PH_END    = 3'd2;
    localparam logic [2:0] PH_BAD    = 3'd3;
    localparam logic [2:0] PH_NONE   = 3'd4;

    logic [2:0]  phase_reg, phase_next, phase_cur;
    logic [31:0] dir_offset_reg, dir_offset_next, off_cur;
    logic [31:0] idx_reg, idx_next, idx_cur, idx_inc;
    logic [31:0] page_reg, page_next;
    logic [31:0] length_reg, length_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] entry;
    logic [31:0] pa;
    logic [32:0] nb_hdr, nb_blk;

    // True when a block header starting at offset nxt fits in the directory
    // and in the buffer.
    function automatic logic room_ok(input logic [32:0] nxt, input brw_pkg::cfg_t c);
        logic [34:0] e;
        e = {2'b00, nxt} + 35'(brw_pkg::HDR_BYTES);
        return (e <= {3'b000, c.dir_size}) &&
               (e + {3'b000, c.dir_rva} <= {3'b000, c.buffer_size});
    endfunction

    always_comb begin
        phase_cur = phase_reg;
        off_cur   = dir_offset_reg;
        idx_cur   = idx_reg;
        if (restart) begin
            off_cur = 32'd0;
            idx_cur = 32'd0;
            if (cfg.delta == 64'd0 || cfg.dir_rva == 32'd0 || cfg.dir_size == 32'd0) begin
                phase_cur = PH_NONE;
            end else if (room_ok(33'd0, cfg)) begin
                phase_cur = PH_ACTIVE;
            end else begin
                phase_cur = PH_END;
            end
        end

        phase_next      = phase_cur;
        dir_offset_next = off_cur;
        idx_next        = idx_cur;
        page_next       = page_reg;
        length_next     = length_reg;
        low_next        = low_reg;
        idx_inc         = idx_cur + 32'd1;
        entry           = {data_byte, low_reg};
        pa              = page_reg + {20'd0, entry[11:0]};
        nb_hdr          = {1'b0, off_cur} + 33'(brw_pkg::HDR_BYTES);
        nb_blk          = {1'b0, off_cur} + {1'b0, length_reg};

        res.action        = brw_pkg::ACT_NONE;
        res.patch_address = 32'd0;
        res.add_value     = 64'd0;

        if (phase_cur == PH_ACTIVE) begin
            idx_next = idx_inc;
            if (idx_cur < 32'd4) begin
                page_next = ((idx_cur == 32'd0) ? 32'd0 : page_reg) |
                            ({24'd0, data_byte} << {idx_cur[1:0], 3'b000});
            end else if (idx_cur < 32'(brw_pkg::HDR_BYTES)) begin
                length_next = ((idx_cur == 32'd4) ? 32'd0 : length_reg) |
                              ({24'd0, data_byte} << {idx_cur[1:0], 3'b000});
                if (idx_cur == 32'(brw_pkg::HDR_BYTES - 1)) begin
                    if (length_next < 32'(brw_pkg::HDR_BYTES) ||
                        length_next > cfg.dir_size) begin
                        phase_next = PH_BAD;
                    end else if ({3'b000, cfg.dir_rva} + {3'b000, off_cur} +
                                 {3'b000, length_next} > {3'b000, cfg.buffer_size}) begin
                        phase_next = PH_END;
                    end else if (length_next == 32'(brw_pkg::HDR_BYTES)) begin
                        // A header-only block: move straight to the next one.
                        if (room_ok(nb_hdr, cfg)) begin
                            dir_offset_next = nb_hdr[31:0];
                            idx_next        = 32'd0;
                        end else begin
                            phase_next = PH_END;
                        end
                    end
                end
            end else begin
                if (!idx_cur[0]) begin
                    low_next = data_byte;
                end else if ({1'b0, pa} + 33'd8 <= {1'b0, cfg.buffer_size}) begin
                    if (entry[15:12] == brw_pkg::TYPE_DIR64) begin
                        res.action        = brw_pkg::ACT_ADD64;
                        res.patch_address = pa;
                        res.add_value     = cfg.delta;
                    end else if (entry[15:12] == brw_pkg::TYPE_HIGHLOW) begin
                        res.action        = brw_pkg::ACT_ADD32;
                        res.patch_address = pa;
                        res.add_value     = {32'd0, cfg.delta[31:0]};
                    end
                end
                if (idx_inc >= length_reg) begin
                    if (room_ok(nb_blk, cfg)) begin
                        dir_offset_next = nb_blk[31:0];
                        idx_next        = 32'd0;
                    end else begin
                        phase_next = PH_END;
                    end
                end
            end
        end

        case (phase_next)
            PH_ACTIVE: res.status = brw_pkg::ST_WALK;
            PH_END:    res.status = brw_pkg::ST_END;
            PH_BAD:    res.status = brw_pkg::ST_BAD;
            default:   res.status = brw_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            dir_offset_reg <= 32'd0;
            idx_reg        <= 32'd0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            dir_offset_reg <= dir_offset_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            page_reg   <= page_next;
            length_reg <= length_next;
            low_reg    <= low_next;
        end
    end

endmodule

@@ rtl/base_relocation_walker.sv @@
// ----------------------------------------------------------------------------
// Base relocation walker
// Streams a relocation directory and emits one result per byte.
// ----------------------------------------------------------------------------
// A result is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the walk state updates in a single step.
// The output register frees itself when its transaction is taken, so a new
// byte is accepted in the same cycle that the previous result is taken.
// Reset (synchronous, active low) clears the configuration, the walk phase,
// offset and byte index and the output valid flag, and leaves the walker
// idle until a byte with restart set arrives.
module base_relocation_walker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_restart,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [31:0] m_patch_address,
    output logic [63:0] m_add_value,
    output logic [1:0]  m_status
);

    brw_pkg::cfg_t cfg_reg;
    brw_pkg::res_t step_res;
    brw_pkg::res_t res_reg;
    logic          m_valid_reg;
    logic          in_fire;
    logic          wr_en;
    logic [1:0]    reg_idx;

    // Registers sit on 8-byte boundaries; the low address bits are not decoded.
    assign reg_idx = paddr[4:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                brw_pkg::REG_DIR_RVA:     cfg_reg.dir_rva     <= pwdata[31:0];
                brw_pkg::REG_DIR_SIZE:    cfg_reg.dir_size    <= pwdata[31:0];
                brw_pkg::REG_BUFFER_SIZE: cfg_reg.buffer_size <= pwdata[31:0];
                brw_pkg::REG_DELTA:       cfg_reg.delta       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            brw_pkg::REG_DIR_RVA:     prdata = {32'd0, cfg_reg.dir_rva};
            brw_pkg::REG_DIR_SIZE:    prdata = {32'd0, cfg_reg.dir_size};
            brw_pkg::REG_BUFFER_SIZE: prdata = {32'd0, cfg_reg.buffer_size};
            brw_pkg::REG_DELTA:       prdata = cfg_reg.delta;
            default:                  prdata = 64'd0;
        endcase
    end

    // The input side stalls only when a result is held and not being taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // The core computes the result and the next walk state combinationally; the
    // walk state advances on every accepted input transaction.
    brw_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (in_fire),
        .data_byte (s_data_byte),
        .restart   (s_restart),
        .cfg       (cfg_reg),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = res_reg.action;
    assign m_patch_address = res_reg.patch_address;
    assign m_add_value     = res_reg.add_value;
    assign m_status        = res_reg.status;

    // A patch is only ever issued while a block is being walked, so the
    // status that goes with it is either still walking or the end of the walk.
    a_patch_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action != brw_pkg::ACT_NONE) |->
        (m_status == brw_pkg::ST_WALK || m_status == brw_pkg::ST_END))
        else $error("patch issued outside an active walk");

    // Results without a patch carry zero address and value.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == brw_pkg::ACT_NONE) |->
        (m_patch_address == 32'd0 && m_add_value == 64'd0))
        else $error("empty result carries a payload");

    // A 32-bit patch never adds anything to the upper word.
    a_add32_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == brw_pkg::ACT_ADD32) |-> (m_add_value[63:32] == 32'd0))
        else $error("32-bit patch with a wide add value");

    // Every accepted byte shows up as a held result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted byte produced no result");

endmodule
